// ----- sv/ks_pkg.sv -----
// ----------------------------------------------------------------------------
// ks_pkg: shared definitions for the key sorter
// Sizes, controller state codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ks_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;        // a key is transferred in this cycle
    logic scan_start;  // restart the search for the next key to emit
    logic issue;       // read the store at the scan address
    logic emit;        // load the best key into the output register
    logic run_clear;   // the run is complete, clear count and flags
  } cmd_t;

  typedef struct packed {
    logic last_addr;   // the scan address is the last held key
    logic out_space;   // the output register can take a result
    logic final_pick;  // the pending result is the last of the run
  } status_t;

endpackage

// ----- sv/ks_ctrl.sv -----
// ----------------------------------------------------------------------------
// ks_ctrl: key sorter controller
// One-hot state machine that sequences loading, repeated selection scans of
// the key store and the transfer of each selected key to the output.
// ----------------------------------------------------------------------------
module ks_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            last_item_i,
  output logic            in_stall_o,
  input  ks_pkg::status_t status_i,
  output ks_pkg::cmd_t    cmd_o
);
  import ks_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_item_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_space) begin
          cmd_o.emit = 1'b1;
          if (status_i.final_pick) begin
            cmd_o.run_clear = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/ks_dpath.sv -----
// ----------------------------------------------------------------------------
// ks_dpath: key sorter datapath
// Key store, run counters, the selection compare over registered store reads
// and the output register.
// ----------------------------------------------------------------------------
module ks_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic [ks_pkg::KEY_W-1:0] key_i,
  input  ks_pkg::cmd_t             cmd_i,
  output ks_pkg::status_t          status_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [ks_pkg::KEY_W-1:0] sorted_key_o,
  output logic                     last_of_run_o,
  output logic                     overflowed_o
);
  import ks_pkg::*;

  logic [KEY_W-1:0]     mem [MAX_ITEMS];
  logic                 desc_q;
  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic [IDX_W-1:0]     scan_idx_q;
  logic [KEY_W-1:0]     rd_key_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_vld_q;
  logic                 best_vld_q;
  logic [KEY_W-1:0]     best_key_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [MAX_ITEMS-1:0] emitted_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_valid_q;
  logic [KEY_W-1:0]     out_key_q;
  logic                 out_last_q;
  logic                 out_ovf_q;

  logic full;
  logic goes_first;
  logic cand_better;

  assign full = (count_q == CNT_W'(MAX_ITEMS));

  // Order test between the key just read and the best key so far.
  assign goes_first  = desc_q ? (rd_key_q > best_key_q) : (rd_key_q < best_key_q);
  assign cand_better = rd_vld_q && !emitted_q[rd_idx_q] && (!best_vld_q || goes_first);

  assign status_o.last_addr  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
  assign status_o.out_space  = !out_valid_q || !out_stall_i;
  assign status_o.final_pick = ((out_cnt_q + CNT_W'(1)) == count_q);

  // Key store: one write port for loading, one registered read port for scans.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[IDX_W-1:0]] <= key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= mem[scan_idx_q];
    rd_idx_q <= scan_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      emitted_q   <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end

      if (cmd_i.run_clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end

      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.issue) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      rd_vld_q <= cmd_i.issue;

      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if (cand_better) begin
        best_vld_q <= 1'b1;
      end

      if (cmd_i.run_clear) begin
        emitted_q <= '0;
        out_cnt_q <= '0;
      end else if (cmd_i.emit) begin
        emitted_q[best_idx_q] <= 1'b1;
        out_cnt_q             <= out_cnt_q + CNT_W'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cmd_i.scan_start && cand_better) begin
      best_key_q <= rd_key_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      out_key_q  <= best_key_q;
      out_last_q <= status_o.final_pick;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sorted_key_o  = out_key_q;
  assign last_of_run_o = out_last_q;
  assign overflowed_o  = out_ovf_q;

endmodule

// ----- sv/key_sorter.sv -----
// ----------------------------------------------------------------------------
// key_sorter: run sorter for unsigned keys
// Collects a run of keys and, once the last key is in, returns the run in
// ascending or descending order with an overflow flag on every result.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                        | Direction
//  --------+------------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, key_i, last_item_i     | in
//  output  | out_valid_o, out_stall_i, sorted_key_o,        | out
//          | last_of_run_o, overflowed_o                    |
//  config  | cfg_we_i, cfg_wdata_i (descending order)       | in
//
// Keys are taken one per cycle while the block is loading. Once the last key
// of a run of n keys has been transferred, each result is found by a full
// scan of the key store through its single registered read port, and the
// next scan starts only after that result is emitted, so any output stall
// delays the run. The input is stalled from the last key until the final
// result has entered the output register. Reset clears the counters, flags,
// order mode and the controller; the key store itself needs no clearing since
// only entries below the held count are ever read.
//
// Keys that arrive while the store is full are dropped and the run is marked
// as overflowed. Among keys of equal value the earliest stored is picked
// first, which is invisible on the output since equal keys are identical.
//
module key_sorter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ks_pkg::KEY_W-1:0] key_i,
  input  logic                     last_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ks_pkg::KEY_W-1:0] sorted_key_o,
  output logic                     last_of_run_o,
  output logic                     overflowed_o
);
  import ks_pkg::*;

  // Commands from the controller and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  ks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the store, the selection compare and the output
  // register, so a finished result can wait there while a new run loads.
  ks_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .key_i         (key_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .sorted_key_o  (sorted_key_o),
    .last_of_run_o (last_of_run_o),
    .overflowed_o  (overflowed_o)
  );

endmodule
